### src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Request and result payloads, command codes, cell values, the controller
// states and the control/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [15:0] BLANK_CELL   = 16'h0F20;
  localparam logic [15:0] RESET_CELL   = 16'h0720;
  localparam logic [7:0]  ATTR_RESET   = 8'd7;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned CELL_W = 16;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] read_cell;
  } tcw_out_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } tcw_state_t;

  typedef struct packed {
    logic accept;
    logic put_exec;
    logic scroll_step;
    logic fill_step;
    logic fill_init;
    logic out_load;
  } tcw_ctl_t;

  typedef struct packed {
    logic wr_pend;
    logic need_scroll;
    logic scroll_last;
    logic fill_last;
    logic out_free;
  } tcw_stat_t;

endpackage

### src/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl: console controller
// Sequences the reset clear pass, put, scroll, fill and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_cmd,
  output logic                  in_ready,
  input  tcw_pkg::tcw_stat_t    stat,
  output tcw_pkg::tcw_ctl_t     ctl
);
  import tcw_pkg::*;

  tcw_state_t state_r;
  tcw_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        ctl.fill_step = 1'b1;
        ctl.fill_init = 1'b1;
        if (stat.fill_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = !stat.wr_pend;
        if (in_valid && !stat.wr_pend) begin
          ctl.accept = 1'b1;
          unique case (in_cmd)
            CMD_PUT:   state_nxt = ST_PUT;
            CMD_CLEAR: state_nxt = ST_FILL;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_PUT: begin
        ctl.put_exec = 1'b1;
        state_nxt    = stat.need_scroll ? ST_SCROLL : ST_DONE;
      end
      ST_SCROLL: begin
        ctl.scroll_step = 1'b1;
        if (stat.scroll_last) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        ctl.fill_step = 1'b1;
        if (stat.fill_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        ctl.out_load = stat.out_free;
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

endmodule

### src/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath: console datapath
// Cell memory with a delayed write slot, cursor, sweep counter, attribute
// register and the result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tcw_pkg::tcw_ctl_t  ctl,
  output tcw_pkg::tcw_stat_t stat,
  input  tcw_pkg::tcw_in_t   in_payload,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               out_ready,
  output logic               out_valid,
  output tcw_pkg::tcw_out_t  out_payload
);
  import tcw_pkg::*;

  localparam int unsigned CELL_COUNT = ROWS * COLUMNS;
  localparam int unsigned MOVE_COUNT = (ROWS - 1) * COLUMNS;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
  localparam int unsigned COL_W      = $clog2(COLUMNS);

  logic [CELL_W-1:0] cells_mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic              wr_src_mem_r, wr_src_mem_nxt;
  logic [CELL_W-1:0] wr_data_r, wr_data_nxt;
  logic [7:0]        attr_r;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              rd_hit_r, rd_hit_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcw_out_t          out_payload_r, out_payload_nxt;

  logic [ADDR_W-1:0] pos;
  logic [31:0]       pos_wide;
  logic              idx_hit;
  logic              is_newline;
  logic              line_end;
  logic              last_row;

  assign pos        = row_base_r + ADDR_W'(col_r);
  assign pos_wide   = 32'(pos);
  assign idx_hit    = 32'(in_payload.cell_index) < CELL_COUNT;
  assign is_newline = char_r == NEWLINE_CODE;
  assign line_end   = is_newline || (col_r == COL_W'(COLUMNS - 1));
  assign last_row   = row_base_r == ADDR_W'(MOVE_COUNT);

  assign stat.wr_pend     = wr_pend_r;
  assign stat.need_scroll = line_end && last_row;
  assign stat.scroll_last = cnt_r == ADDR_W'(MOVE_COUNT - 1);
  assign stat.fill_last   = cnt_r == ADDR_W'(CELL_COUNT - 1);
  assign stat.out_free    = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  always_comb begin
    row_base_nxt    = row_base_r;
    col_nxt         = col_r;
    cnt_nxt         = cnt_r;
    wr_pend_nxt     = 1'b0;
    wr_addr_nxt     = wr_addr_r;
    wr_src_mem_nxt  = wr_src_mem_r;
    wr_data_nxt     = wr_data_r;
    char_nxt        = char_r;
    rd_hit_nxt      = rd_hit_r;
    rd_en           = 1'b0;
    rd_addr         = '0;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_payload_nxt = out_payload_r;

    if (ctl.accept) begin
      cnt_nxt    = '0;
      char_nxt   = in_payload.char_code;
      rd_hit_nxt = (in_payload.cmd == CMD_READ) && idx_hit;
      if (in_payload.cmd == CMD_CLEAR) begin
        row_base_nxt = '0;
        col_nxt      = '0;
      end
      if ((in_payload.cmd == CMD_READ) && idx_hit) begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(in_payload.cell_index);
      end
    end

    if (ctl.put_exec) begin
      if (!is_newline) begin
        wr_pend_nxt    = 1'b1;
        wr_addr_nxt    = pos;
        wr_src_mem_nxt = 1'b0;
        wr_data_nxt    = {attr_r, char_r};
      end
      if (line_end) begin
        col_nxt = '0;
        if (!last_row) begin
          row_base_nxt = row_base_r + ADDR_W'(COLUMNS);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end

    if (ctl.scroll_step) begin
      rd_en          = 1'b1;
      rd_addr        = cnt_r + ADDR_W'(COLUMNS);
      wr_pend_nxt    = 1'b1;
      wr_addr_nxt    = cnt_r;
      wr_src_mem_nxt = 1'b1;
      cnt_nxt        = cnt_r + ADDR_W'(1);
    end

    if (ctl.fill_step) begin
      wr_pend_nxt    = 1'b1;
      wr_addr_nxt    = cnt_r;
      wr_src_mem_nxt = 1'b0;
      wr_data_nxt    = ctl.fill_init ? RESET_CELL : BLANK_CELL;
      cnt_nxt        = cnt_r + ADDR_W'(1);
    end

    if (ctl.out_load) begin
      out_valid_nxt              = 1'b1;
      out_payload_nxt.cursor_pos = pos_wide[POS_W-1:0];
      out_payload_nxt.read_cell  = rd_hit_r ? rdata_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_base_r  <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      attr_r      <= ATTR_RESET;
    end else begin
      row_base_r  <= row_base_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r     <= wr_addr_nxt;
    wr_src_mem_r  <= wr_src_mem_nxt;
    wr_data_r     <= wr_data_nxt;
    char_r        <= char_nxt;
    rd_hit_r      <= rd_hit_nxt;
    out_payload_r <= out_payload_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      cells_mem[wr_addr_r] <= wr_src_mem_r ? rdata_r : wr_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= cells_mem[rd_addr];
    end
  end

endmodule

### src/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// Character put with newline, wrap and scroll, screen clear and cell read
// over a ROWS x COLUMNS store of 16-bit cells.
// ----------------------------------------------------------------------------
// One request at a time. A read or an unused command goes from acceptance
// straight to the result register, a put through the put step first. A put
// that leaves the last row then scrolls: the scroll copies one cell per
// cycle through the cell memory, reading one cell while writing another,
// and then blanks the bottom row.
// After reset, in_ready stays low while the memory is filled with 0x0720.
// A finished result waits in the output register; the next request is still
// accepted, but its result is not loaded until the waiting one is taken.
module text_console_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcw_pkg::tcw_in_t  in_payload,
  output logic              out_valid,
  input  logic              out_ready,
  output tcw_pkg::tcw_out_t out_payload,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);
  import tcw_pkg::*;

  tcw_ctl_t  ctl;
  tcw_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_payload.cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .stat        (stat),
    .in_payload  (in_payload),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_payload (out_payload)
  );

endmodule

### src/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks of the text console writer
// Result hold, cursor range, clear pass after reset and one request in
// flight at a time.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input tcw_pkg::tcw_out_t out_payload
);
  import tcw_pkg::*;

  localparam int unsigned CELL_COUNT = ROWS * COLUMNS;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CELL_COUNT > 2048) || (32'(out_payload.cursor_pos) < CELL_COUNT))
    else $error("cursor position out of range");

  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready)
    else $error("request taken during clear pass");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken back to back");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (.*);

### test/text_console_writer_tb.sv
// ----------------------------------------------------------------------------
// text_console_writer_tb: self-checking bench for the text console writer
// Drives put, clear, read and unused-command requests over valid/ready,
// tracks the expected screen, cursor and attribute in a local screen model
// and compares every result field by field. Covers wrap and scroll at the
// bottom row, out-of-range reads, attribute writes between phases, random
// idling on both sides, a long result stall and a full drain.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int COLS    = 80;
  localparam int LINES   = 25;
  localparam int CELLS   = COLS * LINES;
  localparam int IDX_MAX = (1 << IDX_W) - 1;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    tcw_in_t  req;
    bit       known;
    tcw_out_t res;
  } console_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  tcw_in_t  in_payload;
  logic     out_valid;
  logic     out_ready;
  tcw_out_t out_payload;
  logic     cfg_we;
  logic [7:0] cfg_wdata;

  // screen model
  logic [15:0] screen_model [CELLS];
  int          row_now;
  int          col_now;
  logic [7:0]  attr_now;

  tcw_out_t     pending_results [$];
  console_row_t directed_rows [$];

  int mismatches;
  int puts_done, feeds_done, scrolls_done, clears_done, reads_done, unused_done;
  int attr_writes;
  bit idling;
  bit hold_pending;

  text_console_writer #(
    .COLUMNS(COLS),
    .ROWS   (LINES)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_payload(out_payload),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void start_next_line();
    col_now = 0;
    if (row_now + 1 < LINES) begin
      row_now++;
    end else begin
      scrolls_done++;
      for (int i = 0; i < (LINES - 1) * COLS; i++) screen_model[i] = screen_model[i + COLS];
      for (int i = (LINES - 1) * COLS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
    end
  endfunction

  function automatic tcw_out_t console_predict(input tcw_in_t req);
    tcw_out_t res;
    res = '0;
    case (req.cmd)
      CMD_PUT: begin
        puts_done++;
        if (req.char_code == NEWLINE_CODE) begin
          feeds_done++;
          start_next_line();
        end else begin
          screen_model[row_now * COLS + col_now] = {attr_now, req.char_code};
          col_now++;
          if (col_now >= COLS) start_next_line();
        end
      end
      CMD_CLEAR: begin
        clears_done++;
        for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
        row_now = 0;
        col_now = 0;
      end
      CMD_READ: begin
        reads_done++;
        if (int'(req.cell_index) < CELLS) res.read_cell = screen_model[int'(req.cell_index)];
      end
      default: unused_done++;
    endcase
    res.cursor_pos = POS_W'(row_now * COLS + col_now);
    return res;
  endfunction

  function automatic tcw_in_t random_request(input int feed_pct);
    tcw_in_t req;
    int      roll;
    roll           = int'($urandom_range(99));
    req.cmd        = CMD_PUT;
    req.char_code  = CHAR_W'($urandom_range(255));
    req.cell_index = IDX_W'($urandom_range(IDX_MAX));
    if (roll < 50) begin
      if (int'($urandom_range(99)) < feed_pct) req.char_code = NEWLINE_CODE;
    end else if (roll == 50) begin
      req.cmd = CMD_CLEAR;
    end else if (roll < 72) begin
      // read just behind the cursor, where fresh characters sit
      req.cmd        = CMD_READ;
      req.cell_index = IDX_W'(row_now * COLS + col_now + IDX_MAX + 1
                              - int'($urandom_range(160)));
    end else if (roll < 92) begin
      req.cmd = CMD_READ;
    end else begin
      req.cmd = CMD_UNUSED;
    end
    return req;
  endfunction

  function automatic tcw_in_t make_request(input logic [1:0] cmd, input logic [7:0] ch,
                                           input int idx);
    tcw_in_t req;
    req.cmd        = cmd;
    req.char_code  = ch;
    req.cell_index = IDX_W'(idx);
    return req;
  endfunction

  function automatic void add_row(input logic [1:0] cmd, input logic [7:0] ch, input int idx,
                                  input bit known, input int pos, input logic [15:0] cell_val);
    console_row_t r;
    r.req            = make_request(cmd, ch, idx);
    r.known          = known;
    r.res.cursor_pos = POS_W'(pos);
    r.res.read_cell  = cell_val;
    directed_rows.push_back(r);
  endfunction

  // Leaves in_valid high after acceptance; the next call lowers it or drives the next request, and a drain lowers it.
  task automatic send_request(input tcw_in_t req, input bit known, input tcw_out_t given);
    int       gap;
    tcw_out_t predicted;
    gap = 0;
    if (idling) while (int'($urandom_range(99)) < 35) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= req;
    do @(posedge clk); while (!in_ready);
    predicted = console_predict(req);
    pending_results.push_back(known ? given : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_attribute(input logic [7:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    attr_now = value;
    attr_writes++;
    cfg_we <= 1'b0;
  endtask

  initial begin : result_sink
    tcw_out_t want;
    int       hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: cursor_pos %0d read_cell %h",
                 out_payload.cursor_pos, out_payload.read_cell);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_payload.cursor_pos !== want.cursor_pos) begin
            $error("cursor_pos: expected %0d, got %0d", want.cursor_pos, out_payload.cursor_pos);
            mismatches++;
          end
          if (out_payload.read_cell !== want.read_cell) begin
            $error("read_cell: expected %h, got %h", want.read_cell, out_payload.read_cell);
            mismatches++;
          end
        end
      end
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idling && int'($urandom_range(99)) < 35);
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_payload = '0;
    out_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    idling     = 1'b1;
    for (int i = 0; i < CELLS; i++) screen_model[i] = RESET_CELL;
    row_now  = 0;
    col_now  = 0;
    attr_now = ATTR_RESET;

    // reset contents, out-of-range reads, ignored fields, put/newline/clear
    add_row(CMD_READ,   8'h00,        0,       1, 0,   RESET_CELL);
    add_row(CMD_READ,   8'hFF,        CELLS-1, 1, 0,   RESET_CELL);
    add_row(CMD_READ,   8'h00,        CELLS,   1, 0,   16'h0000);
    add_row(CMD_READ,   8'h55,        IDX_MAX, 1, 0,   16'h0000);
    add_row(CMD_UNUSED, 8'hFF,        IDX_MAX, 1, 0,   16'h0000);
    add_row(CMD_UNUSED, NEWLINE_CODE, 0,       1, 0,   16'h0000);
    add_row(CMD_PUT,    8'h41,        IDX_MAX, 1, 1,   16'h0000);
    add_row(CMD_READ,   8'h00,        0,       1, 1,   16'h0741);
    add_row(CMD_PUT,    8'h00,        0,       1, 2,   16'h0000);
    add_row(CMD_PUT,    8'hFF,        0,       1, 3,   16'h0000);
    add_row(CMD_READ,   NEWLINE_CODE, 2,       1, 3,   16'h07FF);
    add_row(CMD_READ,   8'h00,        1,       1, 3,   16'h0700);
    add_row(CMD_PUT,    NEWLINE_CODE, 0,       1, 80,  16'h0000);
    add_row(CMD_PUT,    NEWLINE_CODE, 0,       1, 160, 16'h0000);
    add_row(CMD_PUT,    8'h0B,        0,       1, 161, 16'h0000);
    add_row(CMD_PUT,    8'h09,        0,       0, 0,   16'h0000);
    add_row(CMD_READ,   8'h00,        160,     1, 162, 16'h070B);
    add_row(CMD_READ,   8'h00,        3,       1, 162, RESET_CELL);
    add_row(CMD_CLEAR,  NEWLINE_CODE, 160,     1, 0,   16'h0000);
    add_row(CMD_READ,   8'h00,        0,       1, 0,   BLANK_CELL);
    add_row(CMD_READ,   8'h00,        CELLS-1, 1, 0,   BLANK_CELL);
    add_row(CMD_CLEAR,  8'h00,        0,       1, 0,   16'h0000);
    add_row(CMD_PUT,    8'h7E,        0,       0, 0,   16'h0000);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_request(directed_rows[i].req, directed_rows[i].known,
                                             directed_rows[i].res);

    // fill the bottom row, wrap past it, then a newline on the bottom row
    drain_results();
    set_attribute(8'h00);
    send_request(make_request(CMD_CLEAR, 8'h00, 0), 1'b0, '0);
    repeat (LINES - 1) send_request(make_request(CMD_PUT, NEWLINE_CODE, 0), 1'b0, '0);
    for (int i = 0; i < COLS; i++)
      send_request(make_request(CMD_PUT, 8'(33 + i), 0), 1'b0, '0);
    for (int k = 0; k < 4; k++)
      send_request(make_request(CMD_READ, 8'h00,
                   k == 0 ? CELLS-2*COLS : k == 1 ? CELLS-COLS-1 : k == 2 ? CELLS-COLS : CELLS-1),
                   1'b0, '0);
    repeat (COLS - 1) send_request(make_request(CMD_PUT, 8'($urandom_range(255)), 0), 1'b0, '0);
    send_request(make_request(CMD_PUT, NEWLINE_CODE, 0), 1'b0, '0);
    send_request(make_request(CMD_READ, 8'h00, CELLS-COLS-1), 1'b0, '0);
    send_request(make_request(CMD_READ, 8'h00, CELLS-1), 1'b0, '0);

    // long result stall while requests keep coming
    drain_results();
    set_attribute(8'hFF);
    hold_pending = 1'b1;
    repeat (20) send_request(random_request(30), 1'b0, '0);

    for (int phase = 0; phase < 9; phase++) begin
      drain_results();
      set_attribute(phase == 8 ? 8'h00 : 8'($urandom_range(255)));
      idling = (phase != 4);
      repeat (100) send_request(random_request(6 + 6 * phase), 1'b0, '0);
    end
    idling = 1'b1;

    drain_results();
    repeat (16) @(posedge clk);
    mismatches += pending_results.size();
    $display("Covered %0d requests: %0d puts (%0d line feeds, %0d scrolls), %0d clears,",
             puts_done + clears_done + reads_done + unused_done, puts_done, feeds_done,
             scrolls_done, clears_done);
    $display("%0d reads, %0d unused commands, %0d attribute writes; %0d mismatches",
             reads_done, unused_done, attr_writes, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
